>>> src/ypf_pkg.sv
`default_nettype none

package ypf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // ln2 in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [63:0] SAT_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HI_PROD_LIMIT = 64'h0000_0000_4000_0000;

  localparam logic [6:0] DIV_STEPS_FULL   = 7'd64;
  localparam logic [6:0] DIV_STEPS_TERM   = 7'd33;
  localparam logic [3:0] EXP_TERMS        = 4'd14;

  localparam logic [2:0] REG_ENERGY_SCALE   = 3'd0;
  localparam logic [2:0] REG_SCREENING_RATE = 3'd1;
  localparam logic [2:0] REG_CUTOFF         = 3'd2;
  localparam logic [2:0] REG_MINIMUM_START  = 3'd3;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic start;
    logic plain;
  } mul_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_POST,
    ST_RR,
    ST_RRC,
    ST_KR,
    ST_EXDIV,
    ST_EXMUL,
    ST_EXDIVK,
    ST_EXEND,
    ST_MA,
    ST_MB,
    ST_MAC,
    ST_MBC,
    ST_MD,
    ST_MF,
    ST_MQ,
    ST_FDIV,
    ST_FMUL,
    ST_FIN,
    ST_DONE
  } seq_state_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/ypf_mul.sv
`default_nettype none

// floor(a*b / 2^32) saturated at 2^62 over four partial products,
// or a plain 32x32 product; one multiplier, registered product
module ypf_mul (
  input  logic              clk,
  input  logic              rst,
  input  ypf_pkg::mul_ctl_t ctl,
  input  logic [63:0]       op_a,
  input  logic [63:0]       op_b,
  output logic              done,
  output logic [63:0]       result
);
  import ypf_pkg::*;

  logic [63:0] a_q, b_q, acc, prod, room, tail;
  logic        plain_q;
  logic [2:0]  phase;
  logic [31:0] mx, my;

  always_comb begin
    case (phase)
      3'd1: begin
        mx = plain_q ? a_q[31:0] : a_q[63:32];
        my = plain_q ? b_q[31:0] : b_q[63:32];
      end
      3'd2: begin
        mx = a_q[63:32];
        my = b_q[31:0];
      end
      3'd3: begin
        mx = a_q[31:0];
        my = b_q[63:32];
      end
      default: begin
        mx = a_q[31:0];
        my = b_q[31:0];
      end
    endcase
    room = SAT_CAP - acc;
    tail = {32'd0, prod[63:32]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 3'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        3'd0: begin
          if (ctl.start) begin
            a_q     <= op_a;
            b_q     <= op_b;
            plain_q <= ctl.plain;
            phase   <= 3'd1;
          end
        end
        3'd1: begin
          prod  <= 64'(mx) * 64'(my);
          phase <= 3'd2;
        end
        3'd2: begin
          if (plain_q) begin
            result <= prod;
            done   <= 1'b1;
            phase  <= 3'd0;
          end else if (prod >= HI_PROD_LIMIT) begin
            result <= SAT_CAP;
            done   <= 1'b1;
            phase  <= 3'd0;
          end else begin
            acc   <= prod << 32;
            prod  <= 64'(mx) * 64'(my);
            phase <= 3'd3;
          end
        end
        3'd3, 3'd4: begin
          if (prod >= room) begin
            result <= SAT_CAP;
            done   <= 1'b1;
            phase  <= 3'd0;
          end else begin
            acc   <= acc + prod;
            prod  <= 64'(mx) * 64'(my);
            phase <= phase + 3'd1;
          end
        end
        3'd5: begin
          result <= (tail >= room) ? SAT_CAP : acc + tail;
          done   <= 1'b1;
          phase  <= 3'd0;
        end
        default: phase <= 3'd0;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/ypf_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle; dividend must fit in steps bits
module ypf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  input  logic [6:0]  steps,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] dq;
  logic [31:0] rem, dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem, dq[63]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq   <= dividend << (7'd64 - steps);
        rem  <= 32'd0;
        dvs  <= divisor;
        cnt  <= steps;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        dq  <= {dq[62:0], fits};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dq;

endmodule

`default_nettype wire

>>> src/ypf_sqrt.sv
`default_nettype none

// floor square root, two radicand bits per cycle
module ypf_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v, res, bitv, trial;
  logic [4:0]  j;
  logic        busy;

  always_comb begin
    bitv  = 64'd1 << {j, 1'b0};
    trial = res + bitv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= radicand;
        res  <= 64'd0;
        j    <= 5'd31;
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        if (j == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          j <= j - 5'd1;
        end
      end
    end
  end

  assign root = res[31:0];

endmodule

`default_nettype wire

>>> src/yukawa_pair_force.sv
`default_nettype none
// Cut-and-shifted Yukawa pair force, one pair at a time.
// The bit-serial divider (two reciprocals, 28 series terms, three unit-vector quotients)
// dominates the run time inside the cutoff; pairs beyond the cutoff skip it.
// One pair at a time: pair_stall holds the input until the sequencer is back in idle.
// A finished result waits in the output register while the next pair is taken.
// Synchronous reset: eps 1.0, kappa 1.0, cutoff 2.0, minima 64.0, energy sum zero.
module yukawa_pair_force #(
  parameter int FRAC_BITS = ypf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  logic signed [31:0] sep_x,
  input  logic signed [31:0] sep_y,
  input  logic signed [31:0] sep_z,
  input  logic [30:0]        radius_first,
  input  logic [30:0]        radius_second,
  input  logic               sweep_start,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic signed [31:0] radial_force,
  output logic signed [31:0] pair_energy,
  output logic               within_cutoff,
  output logic [30:0]        pair_distance,
  output logic signed [47:0] energy_total,
  output logic [30:0]        least_distance,
  output logic signed [31:0] least_gap,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ypf_pkg::*;

  localparam int          UP         = 32 - FRAC_BITS;
  localparam logic [63:0] RECIP_ONE  = 64'd1 << (32 + FRAC_BITS);
  localparam logic [63:0] EXP_LIMIT  = 64'd32 << FRAC_BITS;
  localparam logic [31:0] EPS_RST    = 32'd1 << FRAC_BITS;
  localparam logic [30:0] KAPPA_RST  = 31'd1 << FRAC_BITS;
  localparam logic [30:0] RC_RST     = 31'd2 << FRAC_BITS;
  localparam logic [30:0] MIN_RST    = 31'd64 << FRAC_BITS;

  // configuration
  logic signed [31:0] energy_scale;
  logic [30:0]        screening_rate, cutoff_distance, minimum_start;

  // sequencer
  seq_state_t state, state_next;
  logic       issued;

  // request and working registers
  logic signed [31:0] sep [3];
  logic [30:0]        rad_a, rad_b;
  logic               sweep;
  logic [1:0]         idx;
  logic [63:0]        sq_sum;
  logic [30:0]        dist_r, dist_nz;
  logic               in_range;
  logic [63:0]        rr, rrc;
  logic [36:0]        x32;
  logic [2:0]         red_j;
  logic               ex_sel;
  logic [5:0]         ex_n;
  logic [31:0]        ex_rem;
  logic [32:0]        ex_t, term;
  logic signed [35:0] ex_s;
  logic [3:0]         ex_k;
  logic [34:0]        e_r, ec_r;
  logic [63:0]        pa, pb, pac, pbc, pd, u_r;
  logic signed [63:0] f_r;
  logic signed [31:0] fr_r, en_r;
  logic signed [31:0] fout [3];

  // sweep state
  logic signed [47:0] energy_sum;
  logic [30:0]        dist_min;
  logic signed [31:0] gap_min;

  // units
  mul_ctl_t    mul_ctl;
  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_done;
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_q;
  logic [31:0] div_divisor;
  logic [6:0]  div_steps;
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;

  // combinational datapath
  logic               slot_free, inside_now;
  logic [30:0]        root_clip;
  logic signed [63:0] h_wide;
  logic signed [31:0] gap_now, gap_base;
  logic [30:0]        dist_base;
  logic [63:0]        x_val, x_up, dterm;
  logic [36:0]        red_sub, red_left;
  logic               red_fit;
  logic [34:0]        s_clip, ex_val;
  logic signed [63:0] p_val, q_val, prod_s, f_val, en_val, fm_val;
  logic [31:0]        sep_mag;
  logic signed [48:0] esum_wide;
  logic signed [47:0] esum_sat;

  ypf_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  ypf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .done      (div_done),
    .quotient  (div_q)
  );

  ypf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign pair_stall = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign slot_free  = !result_valid || !result_stall;

  always_comb begin
    sep_mag    = mag32(sep[idx]);
    root_clip  = sqrt_root[31] ? 31'h7FFF_FFFF : sqrt_root[30:0];
    inside_now = dist_r < cutoff_distance;
    h_wide     = $signed({33'd0, dist_r}) - $signed({33'd0, rad_a})
                 - $signed({33'd0, rad_b});
    gap_now    = sat32(h_wide);
    dist_base  = sweep ? minimum_start : dist_min;
    gap_base   = sweep ? $signed({1'b0, minimum_start}) : gap_min;
    x_val      = mul_res >> FRAC_BITS;
    x_up       = x_val << UP;
    dterm      = {33'd0, 31'(cutoff_distance - dist_r)} << UP;
    // ln2 reduction by shift and subtract, quotient below 64
    red_sub    = {5'd0, LN2_Q32} << red_j;
    red_fit    = x32 >= red_sub;
    red_left   = red_fit ? x32 - red_sub : x32;
    s_clip     = ex_s[35] ? 35'd0 : ex_s[34:0];
    ex_val     = s_clip >> ex_n;
    p_val      = $signed(pb) - $signed(pbc);
    q_val      = $signed(pa) - $signed(pac) - $signed(pd);
    prod_s     = $signed(mul_res);
    f_val      = (energy_scale[31] != p_val[63]) ? -prod_s : prod_s;
    en_val     = (energy_scale[31] != q_val[63]) ? -prod_s : prod_s;
    // force opposes the separation when f and s share a sign
    fm_val     = (f_r[63] == sep[idx][31]) ? -prod_s : prod_s;
    esum_wide  = {energy_sum[47], energy_sum} + {{17{en_r[31]}}, en_r};
    if (esum_wide[48] != esum_wide[47])
      esum_sat = esum_wide[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    else
      esum_sat = esum_wide[47:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (pair_valid) state_next = ST_SQ;
      ST_SQ:     if (mul_done && idx == 2'd2) state_next = ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_next = ST_POST;
      ST_POST:   state_next = inside_now ? ST_RR : ST_DONE;
      ST_RR:     if (div_done) state_next = ST_RRC;
      ST_RRC:    if (div_done) state_next = ST_KR;
      ST_KR:     if (mul_done) state_next = (x_val >= EXP_LIMIT) ? ST_EXEND : ST_EXDIV;
      ST_EXDIV:  if (red_j == 3'd0) state_next = ST_EXMUL;
      ST_EXMUL:  if (mul_done) state_next = ST_EXDIVK;
      ST_EXDIVK: if (div_done) state_next = (ex_k == EXP_TERMS) ? ST_EXEND : ST_EXMUL;
      ST_EXEND:  state_next = ex_sel ? ST_MA : ST_KR;
      ST_MA:     if (mul_done) state_next = ST_MB;
      ST_MB:     if (mul_done) state_next = ST_MAC;
      ST_MAC:    if (mul_done) state_next = ST_MBC;
      ST_MBC:    if (mul_done) state_next = ST_MD;
      ST_MD:     if (mul_done) state_next = ST_MF;
      ST_MF:     if (mul_done) state_next = ST_MQ;
      ST_MQ:     if (mul_done) state_next = ST_FDIV;
      ST_FDIV:   if (div_done) state_next = ST_FMUL;
      ST_FMUL:   if (mul_done) state_next = (idx == 2'd2) ? ST_FIN : ST_FDIV;
      ST_FIN:    state_next = ST_DONE;
      ST_DONE:   if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // unit requests and operands
  always_comb begin
    mul_ctl      = '0;
    mul_a        = 64'd0;
    mul_b        = 64'd0;
    div_start    = 1'b0;
    div_dividend = 64'd0;
    div_divisor  = 32'd1;
    div_steps    = DIV_STEPS_FULL;
    sqrt_start   = 1'b0;
    case (state)
      ST_SQ: begin
        mul_ctl = '{start: !issued, plain: 1'b1};
        mul_a   = {32'd0, sep_mag};
        mul_b   = {32'd0, sep_mag};
      end
      ST_SQRT: sqrt_start = !issued;
      ST_RR: begin
        div_start    = !issued;
        div_dividend = RECIP_ONE;
        div_divisor  = {1'b0, dist_nz};
      end
      ST_RRC: begin
        div_start    = !issued;
        div_dividend = RECIP_ONE;
        div_divisor  = {1'b0, cutoff_distance};
      end
      ST_KR: begin
        mul_ctl = '{start: !issued, plain: 1'b1};
        mul_a   = {33'd0, screening_rate};
        mul_b   = {33'd0, ex_sel ? cutoff_distance : dist_r};
      end
      ST_EXMUL: begin
        mul_ctl = '{start: !issued, plain: 1'b1};
        mul_a   = {32'd0, ex_t[31:0]};
        mul_b   = {32'd0, ex_rem};
      end
      ST_EXDIVK: begin
        div_start    = !issued;
        div_dividend = {31'd0, term};
        div_divisor  = {28'd0, ex_k};
        div_steps    = DIV_STEPS_TERM;
      end
      ST_MA: begin
        mul_ctl = '{start: !issued, plain: 1'b0};
        mul_a   = {29'd0, e_r};
        mul_b   = rr;
      end
      ST_MB: begin
        mul_ctl = '{start: !issued, plain: 1'b0};
        mul_a   = pa;
        mul_b   = rr + ({33'd0, screening_rate} << UP);
      end
      ST_MAC: begin
        mul_ctl = '{start: !issued, plain: 1'b0};
        mul_a   = {29'd0, ec_r};
        mul_b   = rrc;
      end
      ST_MBC: begin
        mul_ctl = '{start: !issued, plain: 1'b0};
        mul_a   = pac;
        mul_b   = rrc + ({33'd0, screening_rate} << UP);
      end
      ST_MD: begin
        mul_ctl = '{start: !issued, plain: 1'b0};
        mul_a   = dterm;
        mul_b   = pbc;
      end
      ST_MF: begin
        mul_ctl = '{start: !issued, plain: 1'b0};
        mul_a   = {32'd0, mag32(energy_scale)};
        mul_b   = mag64(p_val);
      end
      ST_MQ: begin
        mul_ctl = '{start: !issued, plain: 1'b0};
        mul_a   = {32'd0, mag32(energy_scale)};
        mul_b   = mag64(q_val);
      end
      ST_FDIV: begin
        div_start    = !issued;
        div_dividend = {sep_mag, 32'd0};
        div_divisor  = {1'b0, dist_nz};
      end
      ST_FMUL: begin
        mul_ctl = '{start: !issued, plain: 1'b0};
        mul_a   = mag64(f_r);
        mul_b   = u_r;
      end
      default: ;
    endcase
  end

  // control, configuration and sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      issued          <= 1'b0;
      result_valid    <= 1'b0;
      energy_scale    <= EPS_RST;
      screening_rate  <= KAPPA_RST;
      cutoff_distance <= RC_RST;
      minimum_start   <= MIN_RST;
      energy_sum      <= 48'sd0;
      dist_min        <= MIN_RST;
      gap_min         <= $signed({1'b0, MIN_RST});
    end else begin
      state <= state_next;
      if (mul_done || div_done || sqrt_done) issued <= 1'b0;
      else if (mul_ctl.start || div_start || sqrt_start) issued <= 1'b1;

      if (state == ST_DONE && slot_free) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          REG_ENERGY_SCALE:   energy_scale    <= cfg_data;
          REG_SCREENING_RATE: screening_rate  <= cfg_data[30:0];
          REG_CUTOFF:         cutoff_distance <= cfg_data[30:0];
          REG_MINIMUM_START:  minimum_start   <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (state == ST_POST) begin
        dist_min <= (dist_r < dist_base) ? dist_r : dist_base;
        gap_min  <= (gap_now < gap_base) ? gap_now : gap_base;
        if (sweep) energy_sum <= 48'sd0;
      end
      if (state == ST_FIN) energy_sum <= esum_sat;
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pair_valid) begin
          sep[0] <= sep_x;
          sep[1] <= sep_y;
          sep[2] <= sep_z;
          rad_a  <= radius_first;
          rad_b  <= radius_second;
          sweep  <= sweep_start;
          sq_sum <= 64'd0;
          idx    <= 2'd0;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          sq_sum <= sq_sum + mul_res;
          idx    <= idx + 2'd1;
        end
      end
      ST_SQRT: if (sqrt_done) dist_r <= root_clip;
      ST_POST: begin
        in_range <= inside_now;
        dist_nz  <= (dist_r == 31'd0) ? 31'd1 : dist_r;
        fout[0]  <= 32'sd0;
        fout[1]  <= 32'sd0;
        fout[2]  <= 32'sd0;
        fr_r     <= 32'sd0;
        en_r     <= 32'sd0;
        ex_sel   <= 1'b0;
      end
      ST_RR:  if (div_done) rr <= div_q;
      ST_RRC: if (div_done) rrc <= div_q;
      ST_KR: begin
        if (mul_done) begin
          // argument of 32 or more: exp underflows to zero
          if (x_val >= EXP_LIMIT) begin
            ex_s <= 36'sd0;
            ex_n <= 6'd0;
          end else begin
            x32   <= x_up[36:0];
            red_j <= 3'd5;
            ex_n  <= 6'd0;
            ex_t  <= 33'h1_0000_0000;
            ex_s  <= 36'sh1_0000_0000;
            ex_k  <= 4'd1;
          end
        end
      end
      ST_EXDIV: begin
        x32    <= red_left;
        ex_n   <= {ex_n[4:0], red_fit};
        ex_rem <= red_left[31:0];
        red_j  <= red_j - 3'd1;
      end
      ST_EXMUL: begin
        // t is 2^32 only on the first term
        if (mul_done)
          term <= {1'b0, mul_res[63:32]} + (ex_t[32] ? {1'b0, ex_rem} : 33'd0);
      end
      ST_EXDIVK: begin
        if (div_done) begin
          ex_t <= div_q[32:0];
          ex_s <= ex_k[0] ? ex_s - $signed({3'd0, div_q[32:0]})
                          : ex_s + $signed({3'd0, div_q[32:0]});
          ex_k <= ex_k + 4'd1;
        end
      end
      ST_EXEND: begin
        if (ex_sel) ec_r <= ex_val;
        else e_r <= ex_val;
        ex_sel <= 1'b1;
      end
      ST_MA:  if (mul_done) pa <= mul_res;
      ST_MB:  if (mul_done) pb <= mul_res;
      ST_MAC: if (mul_done) pac <= mul_res;
      ST_MBC: if (mul_done) pbc <= mul_res;
      ST_MD:  if (mul_done) pd <= mul_res;
      ST_MF: begin
        if (mul_done) begin
          f_r  <= f_val;
          fr_r <= sat32(f_val);
        end
      end
      ST_MQ: begin
        if (mul_done) begin
          en_r <= sat32(en_val);
          idx  <= 2'd0;
        end
      end
      ST_FDIV: if (div_done) u_r <= div_q;
      ST_FMUL: begin
        if (mul_done) begin
          fout[idx] <= sat32(fm_val);
          idx       <= idx + 2'd1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          force_x        <= fout[0];
          force_y        <= fout[1];
          force_z        <= fout[2];
          radial_force   <= fr_r;
          pair_energy    <= en_r;
          within_cutoff  <= in_range;
          pair_distance  <= dist_r;
          energy_total   <= energy_sum;
          least_distance <= dist_min;
          least_gap      <= gap_min;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> tb/yukawa_pair_force_test.sv
`default_nettype none

module yukawa_pair_force_test;
  import ypf_pkg::*;

  localparam int FB = 16;
  localparam longint unsigned CAP62 = 64'h4000_0000_0000_0000;
  localparam longint unsigned LN2 = 64'd2977044472;
  localparam longint E48_TOP = 64'sd140737488355327;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int HOLD_CYCLES = 6000;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic [30:0]        ra;
    logic [30:0]        rb;
    logic               sw;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [31:0] fr;
    logic signed [31:0] en;
    logic               in_cut;
    logic [30:0]        rdist;
    logic signed [47:0] etot;
    logic [30:0]        dmin;
    logic signed [31:0] gmin;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  pair_t cur = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  force_t got;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the registers and sweep state
  longint eps_q = 65536;
  longint unsigned kappa_q = 65536;
  longint unsigned cut_q = 131072;
  longint unsigned minstart_q = 4194304;
  longint esum_q = 0;
  longint unsigned dmin_q = 4194304;
  longint gmin_q = 4194304;

  pair_t pending[$];
  force_t predicted[$];
  int send_idle = 0;
  int recv_stall = 0;
  logic hold_req = 1'b0;
  int hold_cnt = 0;
  int errors = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  yukawa_pair_force uut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall),
    .sep_x(cur.sx), .sep_y(cur.sy), .sep_z(cur.sz),
    .radius_first(cur.ra), .radius_second(cur.rb), .sweep_start(cur.sw),
    .result_valid(result_valid), .result_stall(result_stall),
    .force_x(got.fx), .force_y(got.fy), .force_z(got.fz),
    .radial_force(got.fr), .pair_energy(got.en), .within_cutoff(got.in_cut),
    .pair_distance(got.rdist), .energy_total(got.etot),
    .least_distance(got.dmin), .least_gap(got.gmin),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  // floor(a*b / 2^32) saturating at 2^62
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    longint unsigned ah, al, bh, bl, s, t;
    ah = a >> 32; al = a & 64'hFFFF_FFFF; bh = b >> 32; bl = b & 64'hFFFF_FFFF;
    t = ah * bh;
    if (t >= (64'd1 << 30)) return CAP62;
    s = t << 32;
    t = ah * bl;
    if (t >= CAP62 - s) return CAP62;
    s += t;
    t = al * bh;
    if (t >= CAP62 - s) return CAP62;
    s += t;
    t = (al * bl) >> 32;
    if (t >= CAP62 - s) return CAP62;
    return s + t;
  endfunction

  function automatic longint qmul_signed(longint a, longint b);
    longint unsigned m;
    m = qmul(absval(a), absval(b));
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned decay(longint unsigned x);
    longint unsigned x32, n, rem, t;
    longint s;
    t = 64'd1 << 32;
    s = 64'sd1 << 32;
    if (x >= (64'd32 << FB)) return 0;
    x32 = x << (32 - FB);
    n = x32 / LN2;
    rem = x32 - n * LN2;
    for (int k = 1; k <= 14; k++) begin
      t = ((t * rem) >> 32) / k;
      if (k % 2 == 1) s -= longint'(t); else s += longint'(t);
    end
    if (s < 0) s = 0;
    return longint'(s) >> n;
  endfunction

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic longint axis_force(longint f, longint s, longint unsigned rl);
    longint unsigned u, m;
    u = (absval(s) << 32) / rl;
    m = qmul(absval(f), u);
    return clip32(((f < 0) == (s < 0)) ? -longint'(m) : longint'(m));
  endfunction

  function automatic force_t yukawa_predict(pair_t p);
    force_t o;
    longint sv[3];
    longint unsigned sum, r, rc, rl, one, rr, rrc, k32, e, ec, a, b, ac, bc, d;
    longint h, pf, qe, f, fo[3], fr, en;
    logic ins;
    sv[0] = p.sx; sv[1] = p.sy; sv[2] = p.sz;
    sum = 0;
    fo[0] = 0; fo[1] = 0; fo[2] = 0; fr = 0; en = 0;
    for (int i = 0; i < 3; i++) sum += absval(sv[i]) * absval(sv[i]);
    if (p.sw) begin
      dmin_q = minstart_q;
      gmin_q = longint'(minstart_q);
      esum_q = 0;
    end
    r = root(sum);
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    if (r < dmin_q) dmin_q = r;
    h = clip32(longint'(r) - longint'({33'd0, p.ra}) - longint'({33'd0, p.rb}));
    if (h < gmin_q) gmin_q = h;
    ins = r < cut_q;
    if (ins) begin
      rc = cut_q;
      rl = (r != 0) ? r : 1;
      one = 64'd1 << (32 + FB);
      rr = one / rl;
      rrc = one / rc;
      k32 = kappa_q << (32 - FB);
      e = decay((kappa_q * r) >> FB);
      ec = decay((kappa_q * rc) >> FB);
      a = qmul(e, rr);
      b = qmul(a, rr + k32);
      ac = qmul(ec, rrc);
      bc = qmul(ac, rrc + k32);
      d = qmul((rc - r) << (32 - FB), bc);
      pf = longint'(b) - longint'(bc);
      qe = longint'(a) - longint'(ac) - longint'(d);
      f = qmul_signed(eps_q, pf);
      fr = clip32(f);
      en = clip32(qmul_signed(eps_q, qe));
      for (int i = 0; i < 3; i++) fo[i] = axis_force(f, sv[i], rl);
      esum_q += en;
      if (esum_q > E48_TOP) esum_q = E48_TOP;
      if (esum_q < -E48_TOP - 1) esum_q = -E48_TOP - 1;
    end
    o.fx = fo[0][31:0]; o.fy = fo[1][31:0]; o.fz = fo[2][31:0];
    o.fr = fr[31:0]; o.en = en[31:0]; o.in_cut = ins;
    o.rdist = r[30:0]; o.etot = esum_q[47:0];
    o.dmin = dmin_q[30:0]; o.gmin = gmin_q[31:0];
    return o;
  endfunction

  // driver: presents the head of the pending queue
  always @(posedge clk) begin : driver
    logic take;
    take = pair_valid && !pair_stall;
    if (take) begin
      predicted.push_back(yukawa_predict(cur));
      void'(pending.pop_front());
    end
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (!pair_valid || take) begin
      if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur <= pending[0];
        pair_valid <= 1'b1;
      end else begin
        pair_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // monitor
  always @(posedge clk) begin : monitor
    force_t want;
    if (!rst && result_valid && !result_stall) begin
      if (predicted.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
      end else begin
        want = predicted.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch f exp %h %h %h act %h %h %h", want.fx, want.fy, want.fz,
                     got.fx, got.fy, got.fz);
            $display("  fr/en/in exp %h %h %b act %h %h %b", want.fr, want.en, want.in_cut,
                     got.fr, got.en, got.in_cut);
            $display("  r/etot/dmin/gmin exp %h %h %h %h act %h %h %h %h", want.rdist,
                     want.etot, want.dmin, want.gmin, got.rdist, got.etot, got.dmin,
                     got.gmin);
          end
        end
      end
    end
    if (rst) result_stall <= 1'b0;
    else result_stall <= (hold_cnt != 0) || ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENERGY_SCALE:   eps_q = longint'(signed'(val));
      REG_SCREENING_RATE: kappa_q = {33'd0, val[30:0]};
      REG_CUTOFF:         cut_q = {33'd0, val[30:0]};
      REG_MINIMUM_START:  minstart_q = {33'd0, val[30:0]};
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !pair_valid && predicted.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic add_pair(longint x, longint y, longint z, longint unsigned a,
                          longint unsigned b, logic s);
    pair_t p;
    p.sx = x[31:0]; p.sy = y[31:0]; p.sz = z[31:0];
    p.ra = a[30:0]; p.rb = b[30:0]; p.sw = s;
    pending.push_back(p);
  endtask

  // mostly pairs near the cutoff scale, some full-range, some near zero
  task automatic add_random();
    pair_t p;
    int mode;
    longint unsigned span;
    mode = $urandom_range(9);
    span = cut_q / 2 + 1;
    if (span > 64'h3FFF_FFFF) span = 64'h3FFF_FFFF;
    p.sw = ($urandom_range(7) == 0);
    p.ra = 31'($urandom); p.rb = 31'($urandom);
    if ($urandom_range(1)) begin
      p.ra = 31'($urandom_range(0, 65536));
      p.rb = 31'($urandom_range(0, 65536));
    end
    if (mode < 7) begin
      p.sx = 32'(longint'($urandom_range(0, 2 * span)) - longint'(span));
      p.sy = 32'(longint'($urandom_range(0, 2 * span)) - longint'(span));
      p.sz = 32'(longint'($urandom_range(0, 2 * span)) - longint'(span));
    end else if (mode < 9) begin
      p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
    end else begin
      p.sx = $signed($urandom_range(0, 6)) - 3;
      p.sy = $signed($urandom_range(0, 6)) - 3;
      p.sz = $signed($urandom_range(0, 6)) - 3;
    end
    pending.push_back(p);
  endtask

  logic [31:0] set_eps[4] = '{32'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFD_04D2};
  logic [31:0] set_kap[4] = '{32'd65536, 32'd0, 32'h7FFF_FFFF, 32'd98304};
  logic [31:0] set_cut[4] = '{32'd131072, 32'h7FFF_FFFF, 32'd1, 32'd327680};
  logic [31:0] set_min[4] = '{32'd4194304, 32'h7FFF_FFFF, 32'd1, 32'd200000};
  int idle_snd[4] = '{0, 77, 0, 31};
  int idle_rcv[4] = '{0, 0, 77, 31};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: extremes, zero distance, cutoff edge, sweep restarts
    add_pair(0, 0, 0, 0, 0, 1'b0);
    add_pair(65536, 0, 0, 0, 0, 1'b0);
    add_pair(0, -65536, 0, 16384, 16384, 1'b0);
    add_pair(0, 0, 131071, 0, 0, 1'b0);
    add_pair(131072, 0, 0, 0, 0, 1'b0);
    add_pair(2147483647, 2147483647, 2147483647, 0, 0, 1'b0);
    add_pair(-2147483648, -2147483648, -2147483648, 0, 0, 1'b0);
    add_pair(30000, -40000, 20000, 2147483647, 2147483647, 1'b0);
    add_pair(-1, 1, -1, 0, 0, 1'b0);
    add_pair(50000, 50000, -50000, 0, 0, 1'b1);
    add_pair(1, 0, 0, 2147483647, 0, 1'b0);
    add_pair(-90000, 10000, 0, 0, 2147483647, 1'b1);
    add_pair(0, 0, 0, 0, 0, 1'b1);
    drain();
    reg_write(REG_CUTOFF, 32'd1);
    add_pair(0, 0, 0, 0, 0, 1'b0);
    add_pair(1, 0, 0, 0, 0, 1'b0);
    drain();
    reg_write(REG_MINIMUM_START, 32'd1);
    add_pair(0, 0, 3, 0, 0, 1'b0);
    add_pair(0, 0, 3, 0, 0, 1'b1);
    drain();

    for (int c = 0; c < 4; c++) begin
      reg_write(REG_ENERGY_SCALE, set_eps[c]);
      reg_write(REG_SCREENING_RATE, set_kap[c]);
      reg_write(REG_CUTOFF, set_cut[c]);
      reg_write(REG_MINIMUM_START, set_min[c]);
      for (int m = 0; m < 4; m++) begin
        @(posedge clk);
        send_idle <= idle_snd[m];
        recv_stall <= idle_rcv[m];
        add_pair(0, 0, 0, 0, 0, 1'b1);
        for (int i = 0; i < 24; i++) add_random();
        drain();
      end
    end

    // long receiver hold-off while requests keep coming
    reg_write(REG_ENERGY_SCALE, 32'd65536);
    reg_write(REG_SCREENING_RATE, 32'd65536);
    reg_write(REG_CUTOFF, 32'd131072);
    @(posedge clk);
    send_idle <= 0;
    recv_stall <= 0;
    hold_req <= 1'b1;
    for (int i = 0; i < 10; i++) add_random();
    @(posedge clk);
    hold_req <= 1'b0;
    drain();

    repeat (2000) @(posedge clk);
    if (errors == 0 && predicted.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> yukawa_pair_force.f
src/ypf_pkg.sv
src/ypf_mul.sv
src/ypf_div.sv
src/ypf_sqrt.sv
src/yukawa_pair_force.sv
tb/yukawa_pair_force_test.sv
